[src/trpd_pkg.sv]
// shared constants and types of the tga rle pixel decoder
`default_nettype none

package trpd_pkg;

  // default width of the image pixel counter
  localparam int unsigned CountWidthDef = 30;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned RunW     = 8;
  localparam int unsigned TotalW   = 30;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 30;
  localparam int unsigned GatherW  = 24;
  localparam int unsigned OutDataW = 40;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_RLE_ENABLE  = 2'd0,
    REG_PIXEL_BYTES = 2'd1,
    REG_ALPHA_USED  = 2'd2,
    REG_PIXEL_TOTAL = 2'd3
  } cfg_reg_e;

  localparam logic [2:0]       PixBytes24    = 3'd3;
  localparam logic [2:0]       PixBytesRst   = 3'd4;
  localparam int unsigned      RepeatBit     = 7;
  localparam logic [ByteW-1:0] Opaque        = 8'hFF;
  localparam logic [RunW-1:0]  MaxRun        = 8'd128;
  localparam logic [1:0]       LastByteWide  = 2'd3;
  localparam logic [1:0]       LastByteNarrow = 2'd2;

endpackage

`default_nettype wire

[src/tga_rle_pixel_decoder_top.sv]
// top level of the tga rle pixel decoder
//
// takes image-data bytes of a truecolor tga on the slave stream (one byte per
// word) and returns decoded rgba pixels on the master stream. in rle mode a
// header byte opens each packet: bit 7 marks a repeat packet, bits 6..0 plus
// one give its pixel count. a repeat packet returns one word carrying the
// clipped run length, a literal packet one word per pixel with run length 1.
// raw mode has no headers. master tlast marks the word that completes the
// image, after which the next byte starts a new image.
// throughput: one byte per cycle, sustained while the receiver takes every
// word, set by the single state update per byte. the pixel word is loaded
// into the output register as its last byte is accepted and can be taken
// in the following cycle.
// when the receiver stalls, the output register holds its word and
// s_axis_tready stays low until that word is taken, so no byte is accepted
// meanwhile, even one that would not complete a pixel.
// reset empties the output register, restores the register defaults (raw,
// 32-bit, alpha used, zero pixels) and waits for a header. writing
// pixel_total also aborts the image in progress. configuration must be
// written only while no work is outstanding; the block does not enforce it.
`default_nettype none

module tga_rle_pixel_decoder_top
  import trpd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // byte stream in
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,   // data_byte
  // pixel stream out
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // red, green, blue, alpha, run_length
  output logic                     m_axis_tlast    // image_end
);

  localparam int unsigned CW = COUNT_WIDTH;

  // configuration registers
  logic              rle_q;
  logic [2:0]        pix_bytes_q;
  logic              alpha_used_q;
  logic [TotalW-1:0] pixel_total_q;

  // decoder state
  logic               expect_hdr_q, expect_hdr_d;
  logic               repeat_q, repeat_d;
  logic [RunW-1:0]    pkt_left_q, pkt_left_d;
  logic [1:0]         bytepos_q, bytepos_d;
  logic [GatherW-1:0] gather_q, gather_d;
  logic [CW-1:0]      img_left_q, img_left_d;

  // output register
  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic                m_last_q, m_last_d;

  logic          s_accept;
  logic          cfg_clear;
  logic          wide;
  logic [1:0]    last_pos;
  logic [31:0]   total_ext;
  logic [CW-1:0] total_load;
  logic [CW-1:0] img_load;
  logic [CW-1:0] img_cur;
  logic [CW-1:0] img_new;
  logic [RunW-1:0] hdr_count;
  logic [RunW-1:0] hdr_count_clip;
  logic [RunW-1:0] run_raw;
  logic [RunW-1:0] run_clip;
  logic [RunW-1:0] pkt_new;
  logic [ByteW-1:0] alpha_c;
  logic [GatherW-1:0] gather_upd;
  logic          pix_done;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  assign cfg_clear = cfg_we_i && (cfg_reg_e'(cfg_addr_i) == REG_PIXEL_TOTAL);

  assign wide     = pix_bytes_q != PixBytes24;
  assign last_pos = wide ? LastByteWide : LastByteNarrow;

  // pixel total truncated or zero-extended to the counter width
  assign total_ext  = {{(32-TotalW){1'b0}}, pixel_total_q};
  assign total_load = total_ext[CW-1:0];
  assign img_load   = (img_left_q == '0) ? total_load : img_left_q;
  // a raw pixel's first byte may open a new image
  assign img_cur    = (!rle_q && bytepos_q == 2'd0) ? img_load : img_left_q;

  // header count, clipped to what remains of the image
  assign hdr_count      = {1'b0, s_axis_tdata[RepeatBit-1:0]} + 8'd1;
  assign hdr_count_clip = (CW'(hdr_count) > img_load) ? img_load[RunW-1:0] : hdr_count;

  // byte slot update of the gathered pixel
  always_comb begin
    gather_upd = gather_q;
    unique case (bytepos_q)
      2'd0:    gather_upd[7:0]   = s_axis_tdata;
      2'd1:    gather_upd[15:8]  = s_axis_tdata;
      2'd2:    gather_upd[23:16] = s_axis_tdata;
      default: gather_upd        = gather_q;
    endcase
  end

  // completed pixel: run length, remaining counts
  assign pix_done = bytepos_q >= last_pos;
  assign run_raw  = (rle_q && repeat_q) ? pkt_left_q : 8'd1;
  assign run_clip = (CW'(run_raw) > img_cur) ? img_cur[RunW-1:0] : run_raw;
  assign img_new  = img_cur - CW'(run_clip);
  assign alpha_c  = (wide && alpha_used_q) ? s_axis_tdata : Opaque;

  always_comb begin
    pkt_new = pkt_left_q;
    if (rle_q && repeat_q) begin
      pkt_new = '0;
    end else if (rle_q && pkt_left_q != '0) begin
      pkt_new = pkt_left_q - 8'd1;
    end
  end

  always_comb begin
    expect_hdr_d = expect_hdr_q;
    repeat_d     = repeat_q;
    pkt_left_d   = pkt_left_q;
    bytepos_d    = bytepos_q;
    gather_d     = gather_q;
    img_left_d   = img_left_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    m_last_d     = m_last_q;

    if (s_accept) begin
      if (rle_q && expect_hdr_q) begin
        // packet header; an empty image drops it
        if (img_load != '0) begin
          img_left_d   = img_load;
          pkt_left_d   = hdr_count_clip;
          repeat_d     = s_axis_tdata[RepeatBit];
          expect_hdr_d = 1'b0;
          bytepos_d    = 2'd0;
        end
      end else if (!(!rle_q && bytepos_q == 2'd0 && img_load == '0)) begin
        gather_d   = gather_upd;
        img_left_d = img_cur;
        if (!pix_done) begin
          bytepos_d = bytepos_q + 2'd1;
        end else begin
          bytepos_d  = 2'd0;
          img_left_d = img_new;
          pkt_left_d = pkt_new;
          if (rle_q && (pkt_new == '0 || img_new == '0)) begin
            pkt_left_d   = '0;
            expect_hdr_d = 1'b1;
          end
          m_valid_d = 1'b1;
          m_data_d  = {run_clip, alpha_c, gather_upd[7:0], gather_upd[15:8],
                       gather_upd[23:16]};
          m_last_d  = img_new == '0;
        end
      end
    end

    // a new pixel total aborts the image in progress
    if (cfg_clear) begin
      expect_hdr_d = 1'b1;
      repeat_d     = 1'b0;
      pkt_left_d   = '0;
      bytepos_d    = 2'd0;
      gather_d     = '0;
      img_left_d   = '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_q         <= 1'b0;
      pix_bytes_q   <= PixBytesRst;
      alpha_used_q  <= 1'b1;
      pixel_total_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_RLE_ENABLE:  rle_q         <= cfg_wdata_i[0];
        REG_PIXEL_BYTES: pix_bytes_q   <= cfg_wdata_i[2:0];
        REG_ALPHA_USED:  alpha_used_q  <= cfg_wdata_i[0];
        REG_PIXEL_TOTAL: pixel_total_q <= cfg_wdata_i[TotalW-1:0];
        default:         rle_q         <= rle_q;
      endcase
    end
  end

  // decoder state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q <= 1'b1;
      repeat_q     <= 1'b0;
      pkt_left_q   <= '0;
      bytepos_q    <= 2'd0;
      gather_q     <= '0;
      img_left_q   <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      expect_hdr_q <= expect_hdr_d;
      repeat_q     <= repeat_d;
      pkt_left_q   <= pkt_left_d;
      bytepos_q    <= bytepos_d;
      gather_q     <= gather_d;
      img_left_q   <= img_left_d;
      m_valid_q    <= m_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

`ifndef SYNTHESIS
  // a packet never holds more than 128 pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni) pkt_left_q <= MaxRun)
    else $error("packet pixel count above 128");

  // run length on the output stays within one packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1 -: RunW] <= MaxRun)
    else $error("run length above 128");

  // in rle mode the pixel that ends the image leaves the decoder awaiting a header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !cfg_clear && rle_q && !expect_hdr_q && pix_done && img_new == '0)
      |=> expect_hdr_q)
    else $error("header not expected after image end");
`endif

endmodule

`default_nettype wire

[tb/tga_rle_pixel_decoder_top_tb.sv]
// testbench of the tga rle pixel decoder: directed byte table, then random phases
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_top_tb
  import trpd_pkg::*;
();

  localparam int unsigned CntW        = CountWidthDef;
  localparam int unsigned HoldCycles  = 300;   // long output stall, fills the block
  localparam int unsigned QuietLimit  = 2000;  // cycles with no word moved
  localparam int unsigned ByteTarget  = 1850;
  localparam int unsigned DrainCycles = 4;     // output register latency plus margin
  localparam int unsigned ShowLimit   = 10;
  localparam int unsigned HoldPhase   = 4;
  localparam logic        KindByte    = 1'b0;
  localparam logic        KindCfg     = 1'b1;

  // one pixel word, packed as {tlast, tdata}
  typedef struct packed {
    logic       img_end;
    logic [7:0] run_len;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // one row of the directed table: a register write or a data byte
  typedef struct packed {
    logic                kind;
    logic                typed;    // expected word typed in below
    cfg_reg_e            idx;      // register rows only
    logic [CfgDataW-1:0] val;      // register value or data byte
    pix_t                want;
  } row_t;

  localparam pix_t NoPix = '0;
  localparam int unsigned DirRows = 34;
  localparam row_t DirTab [DirRows] = '{
    // raw mode, empty image: byte is dropped
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h12, NoPix},
    '{KindCfg,  1'b0, REG_PIXEL_TOTAL, 30'd2, NoPix},
    // raw 32-bit, all zero then all ones, second pixel ends the image
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h00, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h00, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h00, NoPix},
    '{KindByte, 1'b1, REG_RLE_ENABLE, 30'h00,
      '{1'b0, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'hFF, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'hFF, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'hFF, NoPix},
    '{KindByte, 1'b1, REG_RLE_ENABLE, 30'hFF,
      '{1'b1, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
    '{KindCfg,  1'b0, REG_RLE_ENABLE, 30'd1, NoPix},
    '{KindCfg,  1'b0, REG_PIXEL_BYTES, 30'd3, NoPix},
    '{KindCfg,  1'b0, REG_PIXEL_TOTAL, 30'd3, NoPix},
    // repeat of 128 overruns a 3-pixel image and is clipped
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'hFF, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h11, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h22, NoPix},
    '{KindByte, 1'b1, REG_RLE_ENABLE, 30'h33,
      '{1'b1, 8'd3, 8'hFF, 8'h11, 8'h22, 8'h33}},
    '{KindCfg,  1'b0, REG_PIXEL_TOTAL, 30'd200, NoPix},
    // literal packet of one pixel
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h00, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h01, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h02, NoPix},
    '{KindByte, 1'b1, REG_RLE_ENABLE, 30'h03,
      '{1'b0, 8'd1, 8'hFF, 8'h01, 8'h02, 8'h03}},
    // literal of 128, pixel width and alpha change after its first byte
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h7F, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'hAA, NoPix},
    '{KindCfg,  1'b0, REG_PIXEL_BYTES, 30'd4, NoPix},
    '{KindCfg,  1'b0, REG_ALPHA_USED, 30'd0, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'hBB, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'hCC, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'hDD, NoPix},
    // raw mode in the middle of the literal packet
    '{KindCfg,  1'b0, REG_RLE_ENABLE, 30'd0, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h80, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h7F, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'h01, NoPix},
    '{KindByte, 1'b0, REG_RLE_ENABLE, 30'hFE, NoPix}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  cfg_reg_e            cfg_addr_i    = REG_RLE_ENABLE;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  tga_rle_pixel_decoder_top #(
    .COUNT_WIDTH(CntW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // register copies, reset values
  logic              mode_rle       = 1'b0;
  logic [2:0]        mode_pix_bytes = PixBytesRst;
  logic              mode_alpha     = 1'b1;
  logic [TotalW-1:0] mode_total     = '0;

  // decoder state copy
  logic            hdr_wait = 1'b1;
  logic            rep_pkt  = 1'b0;
  logic [7:0]      pkt_left = '0;
  logic [1:0]      byte_pos = '0;
  logic [23:0]     gather   = '0;
  logic [CntW-1:0] img_left = '0;

  pix_t pending_pixels [$];

  logic no_idle  = 1'b0;
  logic hold_req = 1'b0;
  int unsigned bytes_used  = 0;
  int unsigned words_seen  = 0;
  int unsigned images_seen = 0;
  int unsigned reg_writes  = 0;
  int unsigned holds_done  = 0;
  int unsigned mismatches  = 0;
  int unsigned quiet_cycles = 0;

  // next decoder state for one byte, and the pixel word it completes
  task automatic decode_byte(input logic [7:0] b, output logic used, output logic got,
                             output pix_t px);
    logic            wide;
    logic [1:0]      last_pos;
    logic [CntW-1:0] cnt;
    logic [CntW-1:0] run;
    used = 1'b1;
    got  = 1'b0;
    px   = '0;
    wide = (mode_pix_bytes != PixBytes24);
    last_pos = wide ? LastByteWide : LastByteNarrow;
    if (mode_rle && hdr_wait) begin
      if (img_left == '0) img_left = mode_total[CntW-1:0];
      if (img_left == '0) begin
        used = 1'b0;
        return;
      end
      cnt = CntW'(b[6:0]) + CntW'(1);
      if (cnt > img_left) cnt = img_left;
      rep_pkt  = b[RepeatBit];
      pkt_left = cnt[7:0];
      hdr_wait = 1'b0;
      byte_pos = '0;
      return;
    end
    // raw mode opens a new image on the first byte of a pixel
    if (!mode_rle && byte_pos == 2'd0) begin
      if (img_left == '0) img_left = mode_total[CntW-1:0];
      if (img_left == '0) begin
        used = 1'b0;
        return;
      end
    end
    if (byte_pos != 2'd3) gather[8*byte_pos +: 8] = b;
    if (byte_pos < last_pos) begin
      byte_pos = byte_pos + 2'd1;
      return;
    end
    byte_pos = '0;
    if (mode_rle && rep_pkt) begin
      run = CntW'(pkt_left);
      pkt_left = '0;
    end else begin
      run = CntW'(1);
      if (mode_rle && pkt_left != '0) pkt_left = pkt_left - 8'd1;
    end
    if (run > img_left) run = img_left;
    img_left = img_left - run;
    if (mode_rle && (pkt_left == '0 || img_left == '0)) begin
      pkt_left = '0;
      hdr_wait = 1'b1;
    end
    got = 1'b1;
    px.red     = gather[23:16];
    px.green   = gather[15:8];
    px.blue    = gather[7:0];
    px.alpha   = (wide && mode_alpha) ? b : Opaque;
    px.run_len = run[7:0];
    px.img_end = (img_left == '0);
  endtask

  // leaves the write enable high; the next byte lowers it
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    reg_writes++;
    case (idx)
      REG_RLE_ENABLE:  mode_rle       = val[0];
      REG_PIXEL_BYTES: mode_pix_bytes = val[2:0];
      REG_ALPHA_USED:  mode_alpha     = val[0];
      REG_PIXEL_TOTAL: begin
        // also aborts the image in progress
        mode_total = val[TotalW-1:0];
        hdr_wait   = 1'b1;
        rep_pkt    = 1'b0;
        pkt_left   = '0;
        byte_pos   = '0;
        gather     = '0;
        img_left   = '0;
      end
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic typed, input pix_t typed_px);
    int   gap;
    logic used;
    logic got;
    pix_t px;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, used, got, px);
    if (used) bytes_used++;
    if (typed) pending_pixels.push_back(typed_px);
    else if (got) pending_pixels.push_back(px);
  endtask

  // stop the byte stream, let every expected word arrive, then let the block go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic check_pixel(input pix_t seen);
    pix_t want;
    words_seen++;
    if (seen.img_end) images_seen++;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= ShowLimit)
        $display("unexpected pixel word %0d: r=%02h g=%02h b=%02h a=%02h run=%0d end=%0b",
                 words_seen, seen.red, seen.green, seen.blue, seen.alpha, seen.run_len,
                 seen.img_end);
      return;
    end
    want = pending_pixels.pop_front();
    if (seen.red !== want.red || seen.green !== want.green || seen.blue !== want.blue ||
        seen.alpha !== want.alpha || seen.run_len !== want.run_len ||
        seen.img_end !== want.img_end) begin
      mismatches++;
      if (mismatches <= ShowLimit) begin
        $display("pixel word %0d mismatch", words_seen);
        $display("  expected r=%02h g=%02h b=%02h a=%02h run=%0d end=%0b",
                 want.red, want.green, want.blue, want.alpha, want.run_len, want.img_end);
        $display("  actual   r=%02h g=%02h b=%02h a=%02h run=%0d end=%0b",
                 seen.red, seen.green, seen.blue, seen.alpha, seen.run_len, seen.img_end);
      end
    end
  endtask

  // pixel sink: random stalls, no-stall stretches and one long hold-off
  initial begin : pixel_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        stall    = HoldCycles;
        hold_req = 1'b0;
        holds_done++;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_pixel({m_axis_tlast, m_axis_tdata});
    end
  end

  // ends a hung run: counts cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("no word moved for %0d cycles, %0d pixel words outstanding",
               QuietLimit, pending_pixels.size());
      $display("tga_rle_pixel_decoder_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : byte_source
    row_t                row;
    logic                after_bytes;
    int unsigned         phase;
    int unsigned         len;
    int unsigned         pick;
    logic [CfgDataW-1:0] r;
    logic [6:0]          hdr_cnt;
    logic [7:0]          b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    after_bytes = 1'b0;
    for (int i = 0; i < DirRows; i++) begin
      row = DirTab[i];
      if (row.kind == KindCfg) begin
        if (after_bytes) settle();
        after_bytes = 1'b0;
        write_reg(row.idx, row.val);
      end else begin
        send_byte(row.val[7:0], row.typed, row.want);
        after_bytes = 1'b1;
      end
    end
    settle();

    // random phases; registers change only between them, so a packet or an
    // image may continue across a mode change when pixel_total is left alone
    phase = 0;
    while (bytes_used < ByteTarget) begin
      if ($urandom_range(0, 3) != 0) begin
        r = CfgDataW'($urandom);
        r[0] = 1'($urandom_range(0, 1));
        write_reg(REG_RLE_ENABLE, r);
      end
      if ($urandom_range(0, 3) != 0) begin
        r = CfgDataW'($urandom);
        pick = $urandom_range(0, 9);
        r[2:0] = (pick < 4) ? PixBytes24 : (pick < 8) ? PixBytesRst : 3'($urandom_range(0, 7));
        write_reg(REG_PIXEL_BYTES, r);
      end
      if ($urandom_range(0, 3) != 0) begin
        r = CfgDataW'($urandom);
        r[0] = 1'($urandom_range(0, 1));
        write_reg(REG_ALPHA_USED, r);
      end
      if ($urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0:       r = '0;
          1:       r = '1;
          2:       r = CfgDataW'($urandom);
          3:       r = CfgDataW'(1);
          default: r = CfgDataW'($urandom_range(2, 40));
        endcase
        write_reg(REG_PIXEL_TOTAL, r);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      len = (mode_total == '0) ? 8 : $urandom_range(20, 90);

      // back-pressure phase: steady raw pixels while the sink holds off
      if (phase == HoldPhase) begin
        write_reg(REG_RLE_ENABLE, '0);
        write_reg(REG_PIXEL_BYTES, CfgDataW'(PixBytes24));
        write_reg(REG_PIXEL_TOTAL, CfgDataW'(600));
        no_idle  = 1'b1;
        hold_req = 1'b1;
        len      = 120;
      end

      repeat (len) begin
        if (mode_rle && hdr_wait) begin
          // mostly short packets so images end often
          hdr_cnt = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 5))
                                                : 7'($urandom_range(0, 127));
          b = {1'($urandom_range(0, 1)), hdr_cnt};
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        send_byte(b, 1'b0, NoPix);
      end
      settle();
      phase++;
    end
    no_idle = 1'b0;

    $display("%0d data bytes over %0d random phases gave %0d pixel words and %0d image ends",
             bytes_used, phase, words_seen, images_seen);
    $display("%0d register writes, %0d long sink hold-offs, %0d mismatches",
             reg_writes, holds_done, mismatches);
    if (mismatches == 0) begin
      $display("tga_rle_pixel_decoder_top regression: pass");
    end else begin
      $display("tga_rle_pixel_decoder_top regression: fail");
    end
    $finish;
  end

endmodule
